// ===== hdl/ifcm_pkg.sv =====
// ============================================================================
// ifcm_pkg
// Shared constants and types of the idle-framed command matcher.
// ============================================================================
package ifcm_pkg;

    localparam int BUFFER_DEPTH  = 64;
    localparam int ADDR_W        = $clog2(BUFFER_DEPTH);
    localparam int PATTERN_BYTES = 8;
    localparam int WIN_IDX_W     = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
    localparam int SEEN_W        = $clog2(PATTERN_BYTES + 1);

    localparam int BYTE_W     = 8;
    localparam int TICK_W     = 32;
    localparam int PAT_W      = 64;
    localparam int PAT_LEN_W  = 4;
    localparam int VERDICT_W  = 2;
    localparam int POS_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(100);

    localparam logic [VERDICT_W-1:0] VERDICT_FAULT    = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_WATCHDOG = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_DATA     = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT    = 3'd0,
        REG_FAULT_PAT  = 3'd1,
        REG_FAULT_LEN  = 3'd2,
        REG_WD_PAT     = 3'd3,
        REG_WD_LEN     = 3'd4
    } cfg_reg_t;

    typedef logic [PATTERN_BYTES-1:0][BYTE_W-1:0] window_t;

endpackage

// ===== hdl/ifcm_channels.sv =====
// ============================================================================
// ifcm channels
// Valid/ready channels for input items and result items.
// ============================================================================
interface ifcm_item_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [ifcm_pkg::BYTE_W-1:0]    rx_byte;
    logic [ifcm_pkg::TICK_W-1:0]    tick_now;

    modport source (output valid, func, rx_byte, tick_now, input ready);
    modport sink   (input valid, func, rx_byte, tick_now, output ready);
endinterface

interface ifcm_result_if;
    logic                           valid;
    logic                           ready;
    logic [ifcm_pkg::VERDICT_W-1:0] verdict;
    logic [ifcm_pkg::BYTE_W-1:0]    data_byte;
    logic [ifcm_pkg::POS_W-1:0]     byte_position;
    logic                           last;

    modport source (output valid, verdict, data_byte, byte_position, last, input ready);
    modport sink   (input valid, verdict, data_byte, byte_position, last, output ready);
endinterface

// ===== hdl/ifcm_ram.sv =====
// ============================================================================
// ifcm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module ifcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/idle_framed_command_matcher_core.sv =====
// ============================================================================
// idle_framed_command_matcher_core
// Buffers received bytes, closes a frame on idle timeout, then reports a
// fault or watchdog command match or replays the frame as plain data.
// ============================================================================
//
//  channel  | direction | transfer carries
//  ---------+-----------+-------------------------------------------------
//  item     | in        | func, rx_byte, tick_now
//  result   | out       | verdict, data_byte, byte_position, last
//  cfg      | in        | cfg_we, cfg_index, cfg_data (write only)
//
//  A byte item is written to the frame store as it is taken. A closing tick
//  scans the frame store (one RAM read per cycle), then gives one verdict
//  or replays the frame one byte at a time, each byte first read from the
//  registered read port of the frame store and then loaded as a result.
//  Items are refused while a frame is scanned, judged or replayed; a stalled
//  result stalls the verdict and the replay. Reset leaves the frame store untouched.
//
module idle_framed_command_matcher_core (
    input  logic                              clk,
    input  logic                              rst_n,
    ifcm_item_if.sink                         item,
    ifcm_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [ifcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ifcm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    state_t                                 state_reg, state_next;
    logic [ifcm_pkg::ADDR_W-1:0]            write_idx_reg, write_idx_next;
    logic [ifcm_pkg::TICK_W-1:0]            last_tick_reg, last_tick_next;
    logic [ifcm_pkg::ADDR_W-1:0]            rd_idx_reg, rd_idx_next;
    logic                                   rd_pend_reg, rd_pend_next;
    logic                                   chk_reg, chk_next;
    ifcm_pkg::window_t                      win_reg, win_next;
    logic [ifcm_pkg::SEEN_W-1:0]            seen_reg, seen_next;
    logic                                   fault_hit_reg, fault_hit_next;
    logic                                   wd_hit_reg, wd_hit_next;

    logic [ifcm_pkg::TICK_W-1:0]            timeout_reg, timeout_next;
    logic [ifcm_pkg::PAT_W-1:0]             fault_pat_reg, fault_pat_next;
    logic [ifcm_pkg::PAT_LEN_W-1:0]         fault_len_reg, fault_len_next;
    logic [ifcm_pkg::PAT_W-1:0]             wd_pat_reg, wd_pat_next;
    logic [ifcm_pkg::PAT_LEN_W-1:0]         wd_len_reg, wd_len_next;

    logic                                   out_valid_reg, out_valid_next;
    logic [ifcm_pkg::VERDICT_W-1:0]         out_verdict_reg, out_verdict_next;
    logic [ifcm_pkg::BYTE_W-1:0]            out_byte_reg, out_byte_next;
    logic [ifcm_pkg::POS_W-1:0]             out_pos_reg, out_pos_next;
    logic                                   out_last_reg, out_last_next;

    logic                                   item_fire;
    logic                                   out_free;
    logic                                   out_load;
    logic [ifcm_pkg::TICK_W-1:0]            elapsed;
    logic                                   ram_we;
    logic                                   ram_re;
    logic [ifcm_pkg::BYTE_W-1:0]            ram_rdata;
    logic                                   emit_last;

    function automatic logic pat_match(
        input ifcm_pkg::window_t                 win,
        input logic [ifcm_pkg::PAT_W-1:0]        pat,
        input logic [ifcm_pkg::PAT_LEN_W-1:0]    len,
        input logic [ifcm_pkg::SEEN_W-1:0]       seen
    );
        logic [ifcm_pkg::PAT_LEN_W-1:0] n;
        logic [ifcm_pkg::PAT_LEN_W-1:0] j;
        logic                           hit;
        n = (len > ifcm_pkg::PAT_LEN_W'(ifcm_pkg::PATTERN_BYTES))
            ? ifcm_pkg::PAT_LEN_W'(ifcm_pkg::PATTERN_BYTES) : len;
        hit = (n != '0) && (ifcm_pkg::PAT_LEN_W'(seen) >= n);
        // newest byte sits at window slot 0, so pattern byte k is slot n-1-k
        for (int k = 0; k < ifcm_pkg::PATTERN_BYTES; k++)
        begin
            j = n - 1'b1 - ifcm_pkg::PAT_LEN_W'(k);
            if ((ifcm_pkg::PAT_LEN_W'(k) < n)
                && (win[j[ifcm_pkg::WIN_IDX_W-1:0]] != pat[8*k +: 8]))
            begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    ifcm_ram #(
        .WIDTH (ifcm_pkg::BYTE_W),
        .DEPTH (ifcm_pkg::BUFFER_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_idx_reg),
        .wdata (item.rx_byte),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign item.ready  = (state_reg == ST_IDLE);
    assign item_fire   = item.valid && item.ready;
    assign out_free    = !out_valid_reg || result.ready;
    assign elapsed     = item.tick_now - last_tick_reg;
    assign ram_we      = item_fire && !item.func;
    assign emit_last   = (rd_idx_reg == ifcm_pkg::ADDR_W'(write_idx_reg - 1'b1));

    assign result.valid         = out_valid_reg;
    assign result.verdict       = out_verdict_reg;
    assign result.data_byte     = out_byte_reg;
    assign result.byte_position = out_pos_reg;
    assign result.last          = out_last_reg;

    // configuration decode
    always_comb
    begin
        timeout_next   = timeout_reg;
        fault_pat_next = fault_pat_reg;
        fault_len_next = fault_len_reg;
        wd_pat_next    = wd_pat_reg;
        wd_len_next    = wd_len_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ifcm_pkg::REG_TIMEOUT:   timeout_next   = cfg_data[ifcm_pkg::TICK_W-1:0];
                ifcm_pkg::REG_FAULT_PAT: fault_pat_next = cfg_data[ifcm_pkg::PAT_W-1:0];
                ifcm_pkg::REG_FAULT_LEN: fault_len_next = cfg_data[ifcm_pkg::PAT_LEN_W-1:0];
                ifcm_pkg::REG_WD_PAT:    wd_pat_next    = cfg_data[ifcm_pkg::PAT_W-1:0];
                ifcm_pkg::REG_WD_LEN:    wd_len_next    = cfg_data[ifcm_pkg::PAT_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // frame sequencer
    always_comb
    begin
        state_next       = state_reg;
        write_idx_next   = write_idx_reg;
        last_tick_next   = last_tick_reg;
        rd_idx_next      = rd_idx_reg;
        rd_pend_next     = 1'b0;
        chk_next         = 1'b0;
        win_next         = win_reg;
        seen_next        = seen_reg;
        fault_hit_next   = fault_hit_reg;
        wd_hit_next      = wd_hit_reg;
        ram_re           = 1'b0;
        out_load         = 1'b0;
        out_verdict_next = out_verdict_reg;
        out_byte_next    = out_byte_reg;
        out_pos_next     = out_pos_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && !item.func)
                begin
                    write_idx_next = (write_idx_reg == ifcm_pkg::ADDR_W'(ifcm_pkg::BUFFER_DEPTH - 1))
                                     ? '0 : write_idx_reg + 1'b1;
                    last_tick_next = item.tick_now;
                end
                else if (item_fire && (write_idx_reg != '0) && (elapsed >= timeout_reg))
                begin
                    rd_idx_next    = '0;
                    seen_next      = '0;
                    fault_hit_next = 1'b0;
                    wd_hit_next    = 1'b0;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle, shift the byte in, check the window
                ram_re       = (rd_idx_reg != write_idx_reg);
                rd_pend_next = ram_re;
                if (ram_re)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (rd_pend_reg)
                begin
                    win_next[0] = ram_rdata;
                    for (int i = 1; i < ifcm_pkg::PATTERN_BYTES; i++)
                    begin
                        win_next[i] = win_reg[i-1];
                    end
                    if (seen_reg < ifcm_pkg::SEEN_W'(ifcm_pkg::PATTERN_BYTES))
                    begin
                        seen_next = seen_reg + 1'b1;
                    end
                end
                chk_next = rd_pend_reg;
                if (chk_reg)
                begin
                    fault_hit_next = fault_hit_reg
                                     || pat_match(win_reg, fault_pat_reg, fault_len_reg, seen_reg);
                    wd_hit_next    = wd_hit_reg
                                     || pat_match(win_reg, wd_pat_reg, wd_len_reg, seen_reg);
                end
                if (!ram_re && !rd_pend_reg && !chk_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (fault_hit_reg || wd_hit_reg)
                begin
                    if (out_free)
                    begin
                        out_load         = 1'b1;
                        out_verdict_next = fault_hit_reg ? ifcm_pkg::VERDICT_FAULT
                                                         : ifcm_pkg::VERDICT_WATCHDOG;
                        out_byte_next    = '0;
                        out_pos_next     = '0;
                        out_last_next    = 1'b1;
                        write_idx_next   = '0;
                        state_next       = ST_IDLE;
                    end
                end
                else
                begin
                    rd_idx_next = '0;
                    state_next  = ST_EMIT_RD;
                end
            end

            ST_EMIT_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_EMIT_OUT;
            end

            ST_EMIT_OUT:
            begin
                // read data holds while the result register is stalled
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_verdict_next = ifcm_pkg::VERDICT_DATA;
                    out_byte_next    = ram_rdata;
                    out_pos_next     = ifcm_pkg::POS_W'(rd_idx_reg);
                    out_last_next    = emit_last;
                    if (emit_last)
                    begin
                        write_idx_next = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        state_next  = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            write_idx_reg   <= '0;
            last_tick_reg   <= '0;
            rd_idx_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            chk_reg         <= 1'b0;
            win_reg         <= '0;
            seen_reg        <= '0;
            fault_hit_reg   <= 1'b0;
            wd_hit_reg      <= 1'b0;
            timeout_reg     <= ifcm_pkg::TIMEOUT_RESET;
            fault_pat_reg   <= '0;
            fault_len_reg   <= '0;
            wd_pat_reg      <= '0;
            wd_len_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_verdict_reg <= '0;
            out_byte_reg    <= '0;
            out_pos_reg     <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            write_idx_reg   <= write_idx_next;
            last_tick_reg   <= last_tick_next;
            rd_idx_reg      <= rd_idx_next;
            rd_pend_reg     <= rd_pend_next;
            chk_reg         <= chk_next;
            win_reg         <= win_next;
            seen_reg        <= seen_next;
            fault_hit_reg   <= fault_hit_next;
            wd_hit_reg      <= wd_hit_next;
            timeout_reg     <= timeout_next;
            fault_pat_reg   <= fault_pat_next;
            fault_len_reg   <= fault_len_next;
            wd_pat_reg      <= wd_pat_next;
            wd_len_reg      <= wd_len_next;
            out_valid_reg   <= out_valid_next;
            out_verdict_reg <= out_verdict_next;
            out_byte_reg    <= out_byte_next;
            out_pos_reg     <= out_pos_next;
            out_last_reg    <= out_last_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_verdict_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_verdict_reg != ifcm_pkg::VERDICT_DATA))
        |-> (out_last_reg && (out_byte_reg == '0)))
        else $error("verdict result without last flag or with data");

    a_last_clears_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_next) |=> (write_idx_reg == '0) && (state_reg == ST_IDLE))
        else $error("frame index not cleared after final result");

    a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE) && !ram_re)
        else $error("frame store written outside idle");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rd_idx_reg <= write_idx_reg))
        else $error("scan read index beyond frame");
`endif

endmodule

// ===== bench/ifcm_frame_check.sv =====
`timescale 1ns / 100ps
// ============================================================================
// ifcm_frame_check
// Watches the item, result and register write ports of the idle-framed
// command matcher, predicts every result of each closed frame and compares
// the result transfers against the predictions in order.
// ============================================================================
module ifcm_frame_check (
    input  logic                            clk,
    input  logic                            rst_n,
    ifcm_item_if                            item,
    ifcm_result_if                          result,
    input  logic                            cfg_we,
    input  logic [ifcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ifcm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            flush_check,
    output int                              outstanding,
    output int                              error_count
);

    typedef struct packed {
        logic [ifcm_pkg::VERDICT_W-1:0] verdict;
        logic [ifcm_pkg::BYTE_W-1:0]    data_byte;
        logic [ifcm_pkg::POS_W-1:0]     byte_position;
        logic                           last;
    } frame_out_t;

    logic [ifcm_pkg::BYTE_W-1:0]    rx_store [ifcm_pkg::BUFFER_DEPTH];
    logic [ifcm_pkg::ADDR_W-1:0]    fill_level;
    logic [ifcm_pkg::TICK_W-1:0]    last_rx_tick;
    logic [ifcm_pkg::TICK_W-1:0]    idle_limit;
    logic [ifcm_pkg::TICK_W-1:0]    idle_span;
    logic [ifcm_pkg::PAT_W-1:0]     fault_pat;
    logic [ifcm_pkg::PAT_W-1:0]     wd_pat;
    logic [ifcm_pkg::PAT_LEN_W-1:0] fault_len;
    logic [ifcm_pkg::PAT_LEN_W-1:0] wd_len;
    frame_out_t                     due_results [$];
    frame_out_t                     seen;
    frame_out_t                     want;
    bit                             flushed;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    function automatic bit frame_holds(input logic [ifcm_pkg::PAT_W-1:0] pat,
                                       input logic [ifcm_pkg::PAT_LEN_W-1:0] len);
        int n;
        int start;
        bit hit;
        n = (len > ifcm_pkg::PATTERN_BYTES) ? ifcm_pkg::PATTERN_BYTES : int'(len);
        if (n == 0 || int'(fill_level) < n)
            return 1'b0;
        for (start = 0; start + n <= int'(fill_level); start++)
        begin
            hit = 1'b1;
            for (int k = 0; k < n; k++)
                if (rx_store[start + k] != pat[8*k +: 8])
                    hit = 1'b0;
            if (hit)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic close_frame();
        frame_out_t r;
        r = '0;
        if (frame_holds(fault_pat, fault_len) || frame_holds(wd_pat, wd_len))
        begin
            // fault command takes priority over the watchdog command
            r.verdict = frame_holds(fault_pat, fault_len) ? ifcm_pkg::VERDICT_FAULT
                                                          : ifcm_pkg::VERDICT_WATCHDOG;
            r.last    = 1'b1;
            due_results.push_back(r);
        end
        else
        begin
            for (int i = 0; i < int'(fill_level); i++)
            begin
                r.verdict       = ifcm_pkg::VERDICT_DATA;
                r.data_byte     = rx_store[i];
                r.byte_position = ifcm_pkg::POS_W'(i);
                r.last          = (i + 1 == int'(fill_level));
                due_results.push_back(r);
            end
        end
        fill_level = '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_level   = '0;
            last_rx_tick = '0;
            idle_limit   = ifcm_pkg::TIMEOUT_RESET;
            fault_pat    = '0;
            wd_pat       = '0;
            fault_len    = '0;
            wd_len       = '0;
            error_count  = 0;
            flushed      = 1'b0;
            due_results.delete();
        end
        else
        begin
            if (cfg_we === 1'b1)
            begin
                case (ifcm_pkg::cfg_reg_t'(cfg_index))
                    ifcm_pkg::REG_TIMEOUT:
                        idle_limit = cfg_data[ifcm_pkg::TICK_W-1:0];
                    ifcm_pkg::REG_FAULT_PAT:
                        fault_pat  = cfg_data[ifcm_pkg::PAT_W-1:0];
                    ifcm_pkg::REG_FAULT_LEN:
                        fault_len  = cfg_data[ifcm_pkg::PAT_LEN_W-1:0];
                    ifcm_pkg::REG_WD_PAT:
                        wd_pat     = cfg_data[ifcm_pkg::PAT_W-1:0];
                    ifcm_pkg::REG_WD_LEN:
                        wd_len     = cfg_data[ifcm_pkg::PAT_LEN_W-1:0];
                    default: ;
                endcase
            end

            if (result.valid === 1'b1 && result.ready === 1'b1)
            begin
                seen = '{result.verdict, result.data_byte, result.byte_position, result.last};
                if (due_results.size() == 0)
                    report_mismatch($sformatf(
                        "unexpected result: verdict %0d byte %02h pos %0d last %0b",
                        seen.verdict, seen.data_byte, seen.byte_position, seen.last));
                else
                begin
                    want = due_results.pop_front();
                    if (seen.verdict !== want.verdict)
                        report_mismatch($sformatf("verdict: got %0d, want %0d",
                                                  seen.verdict, want.verdict));
                    if (seen.data_byte !== want.data_byte)
                        report_mismatch($sformatf("data_byte at pos %0d: got %02h, want %02h",
                                                  want.byte_position, seen.data_byte,
                                                  want.data_byte));
                    if (seen.byte_position !== want.byte_position)
                        report_mismatch($sformatf("byte_position: got %0d, want %0d",
                                                  seen.byte_position, want.byte_position));
                    if (seen.last !== want.last)
                        report_mismatch($sformatf("last at pos %0d: got %0b, want %0b",
                                                  want.byte_position, seen.last, want.last));
                end
            end

            if (item.valid === 1'b1 && item.ready === 1'b1)
            begin
                if (item.func == 1'b0)
                begin
                    // index wraps at the store depth, so a full store reads as empty
                    rx_store[fill_level] = item.rx_byte;
                    fill_level++;
                    last_rx_tick = item.tick_now;
                end
                else
                begin
                    idle_span = item.tick_now - last_rx_tick;
                    if (fill_level != '0 && idle_span >= idle_limit)
                        close_frame();
                end
            end

            if (flush_check === 1'b1 && !flushed)
            begin
                flushed = 1'b1;
                foreach (due_results[i])
                    report_mismatch($sformatf("missing result: verdict %0d byte %02h pos %0d",
                                              due_results[i].verdict, due_results[i].data_byte,
                                              due_results[i].byte_position));
                due_results.delete();
            end
        end
        outstanding = due_results.size();
    end

endmodule

// ===== bench/tb_idle_framed_command_matcher_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_idle_framed_command_matcher_core
// Drives byte and tick items through the matcher under several register
// settings, with random idle bursts on both channels; the frame checker
// beside the block predicts and compares every result.
// ============================================================================
module tb_idle_framed_command_matcher_core;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int PHASE_ITEMS    = 58;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [ifcm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ifcm_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            flush_check;
    int                              outstanding;
    int                              error_count;

    logic [ifcm_pkg::TICK_W-1:0]     timeout_now;
    logic [ifcm_pkg::TICK_W-1:0]     tick_cursor;
    logic [ifcm_pkg::TICK_W-1:0]     last_sent_tick;
    logic [ifcm_pkg::PAT_W-1:0]      cur_fault_pat;
    logic [ifcm_pkg::PAT_W-1:0]      cur_wd_pat;
    logic [ifcm_pkg::PAT_LEN_W-1:0]  cur_fault_len;
    logic [ifcm_pkg::PAT_LEN_W-1:0]  cur_wd_len;
    int                              items_sent;
    bit                              src_idle_on;
    bit                              sink_idle_on;
    int                              stall_left;
    int                              quiet_cycles;

    ifcm_item_if   item ();
    ifcm_result_if result ();

    idle_framed_command_matcher_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ifcm_frame_check frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .flush_check (flush_check),
        .outstanding (outstanding),
        .error_count (error_count)
    );

    always #5 clk = ~clk;

    // result side: stall in random bursts while sink idling is on
    always @(negedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result.ready <= 1'b0;
        end
        else if (sink_idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            result.ready <= 1'b0;
        end
        else
            result.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((item.valid === 1'b1 && item.ready === 1'b1) ||
            (result.valid === 1'b1 && result.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so the caller either sends again or holds off.
    task automatic send_item(input logic f, input logic [ifcm_pkg::BYTE_W-1:0] b,
                             input logic [ifcm_pkg::TICK_W-1:0] t);
        items_sent++;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        item.valid    <= 1'b1;
        item.func     <= f;
        item.rx_byte  <= b;
        item.tick_now <= t;
        do
            @(posedge clk);
        while (item.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic send_byte_at(input logic [ifcm_pkg::BYTE_W-1:0] b,
                                input logic [ifcm_pkg::TICK_W-1:0] t);
        last_sent_tick = t;
        send_item(1'b0, b, t);
    endtask

    task automatic push_byte(input logic [ifcm_pkg::BYTE_W-1:0] b);
        tick_cursor = tick_cursor + $urandom_range(0, 3);
        send_byte_at(b, tick_cursor);
    endtask

    // tick that stays short of the timeout, half the time by exactly one
    task automatic early_tick();
        logic [ifcm_pkg::TICK_W-1:0] span;
        if (timeout_now != '0)
        begin
            span = $urandom_range(0, 1) ? timeout_now - 1 : $urandom_range(0, timeout_now - 1);
            send_item(1'b1, ifcm_pkg::BYTE_W'($urandom), last_sent_tick + span);
        end
    endtask

    task automatic closing_tick();
        logic [ifcm_pkg::TICK_W-1:0] span;
        span = timeout_now;
        if ($urandom_range(0, 2) != 0)
            span = span + $urandom_range(0, ~timeout_now);
        tick_cursor = last_sent_tick + span;
        send_item(1'b1, ifcm_pkg::BYTE_W'($urandom), tick_cursor);
    endtask

    task automatic settle();
        item.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input ifcm_pkg::cfg_reg_t r,
                           input logic [ifcm_pkg::CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(negedge clk);
    endtask

    task automatic write_settings(input logic [ifcm_pkg::TICK_W-1:0] tmo,
                                  input logic [ifcm_pkg::PAT_W-1:0] fpat,
                                  input logic [ifcm_pkg::PAT_LEN_W-1:0] flen,
                                  input logic [ifcm_pkg::PAT_W-1:0] wpat,
                                  input logic [ifcm_pkg::PAT_LEN_W-1:0] wlen);
        put_reg(ifcm_pkg::REG_TIMEOUT, ifcm_pkg::CFG_DATA_W'(tmo));
        put_reg(ifcm_pkg::REG_FAULT_PAT, fpat);
        put_reg(ifcm_pkg::REG_FAULT_LEN, ifcm_pkg::CFG_DATA_W'(flen));
        put_reg(ifcm_pkg::REG_WD_PAT, wpat);
        put_reg(ifcm_pkg::REG_WD_LEN, ifcm_pkg::CFG_DATA_W'(wlen));
        cfg_we        <= 1'b0;
        timeout_now   = tmo;
        cur_fault_pat = fpat;
        cur_fault_len = flen;
        cur_wd_pat    = wpat;
        cur_wd_len    = wlen;
        @(negedge clk);
    endtask

    // bytes drawn from the command patterns make partial and accidental hits likely
    function automatic logic [ifcm_pkg::BYTE_W-1:0] near_pattern_byte();
        case ($urandom_range(0, 3))
            0: return cur_fault_pat[8*$urandom_range(0, ifcm_pkg::PATTERN_BYTES-1) +: 8];
            1: return cur_wd_pat[8*$urandom_range(0, ifcm_pkg::PATTERN_BYTES-1) +: 8];
            2: return 8'h00;
            default: return 8'hFF;
        endcase
    endfunction

    task automatic send_frame();
        logic [ifcm_pkg::BYTE_W-1:0]    body [80];
        logic [ifcm_pkg::PAT_W-1:0]     pat;
        logic [ifcm_pkg::PAT_LEN_W-1:0] len_cfg;
        int                             n;
        int                             pick;
        int                             at;
        int                             plen;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            n = $urandom_range(1, 10);
        else if (pick < 93)
            n = $urandom_range(11, 40);
        else
            n = $urandom_range(60, 66);
        for (int i = 0; i < n; i++)
            body[i] = $urandom_range(0, 1) ? ifcm_pkg::BYTE_W'($urandom) : near_pattern_byte();

        pick    = $urandom_range(0, 9);
        pat     = (pick < 5) ? cur_fault_pat : cur_wd_pat;
        len_cfg = (pick < 5) ? cur_fault_len : cur_wd_len;
        plen    = (len_cfg > ifcm_pkg::PATTERN_BYTES) ? ifcm_pkg::PATTERN_BYTES : int'(len_cfg);
        if (pick < 8 && plen > 0 && plen <= n)
        begin
            at = $urandom_range(0, n - plen);
            for (int k = 0; k < plen; k++)
                body[at + k] = pat[8*k +: 8];
            // flip one bit now and then to make a near miss
            if ($urandom_range(0, 3) == 0)
                body[at + $urandom_range(0, plen - 1)] ^=
                    ifcm_pkg::BYTE_W'(1) << $urandom_range(0, 7);
        end

        if ($urandom_range(0, 3) == 0)
            tick_cursor = $urandom;
        if ($urandom_range(0, 9) == 0)
            send_item(1'b1, ifcm_pkg::BYTE_W'($urandom), ifcm_pkg::TICK_W'($urandom));
        for (int i = 0; i < n; i++)
        begin
            push_byte(body[i]);
            if ($urandom_range(0, 11) == 0)
                early_tick();
        end
        if ($urandom_range(0, 4) == 0)
            early_tick();
        closing_tick();
    endtask

    task automatic run_phase(input bit quiet_end);
        int start;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            src_idle_on  = !quiet_end && $urandom_range(0, 2) != 0;
            sink_idle_on = !quiet_end && $urandom_range(0, 2) != 0;
            send_frame();
        end
        settle();
    endtask

    initial
    begin : stimulus
        logic [ifcm_pkg::BYTE_W-1:0] both_cmds [5];
        both_cmds     = '{8'h01, 8'h02, 8'h03, 8'hAA, 8'h55};
        rst_n         = 1'b0;
        item.valid    = 1'b0;
        item.func     = 1'b0;
        item.rx_byte  = '0;
        item.tick_now = '0;
        result.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        flush_check   = 1'b0;
        stall_left    = 0;
        quiet_cycles  = 0;
        items_sent    = 0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        timeout_now   = ifcm_pkg::TIMEOUT_RESET;
        cur_fault_pat = '0;
        cur_wd_pat    = '0;
        cur_fault_len = '0;
        cur_wd_len    = '0;
        tick_cursor   = $urandom;
        last_sent_tick = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: timeout of 100 and both commands disabled
        send_byte_at(8'h5A, 32'd10);
        send_item(1'b1, 8'hFF, 32'd109);
        send_item(1'b1, 8'h00, 32'd110);
        settle();

        write_settings(32'd5, 64'h55AA, 4'd2, 64'h03_0201, 4'd3);
        send_item(1'b1, 8'h00, 32'd1000);
        // frame straddles the tick counter wrap
        send_byte_at(8'h00, 32'hFFFF_FFFE);
        send_byte_at(8'hFF, 32'hFFFF_FFFF);
        send_item(1'b1, 8'h00, 32'd2);
        send_item(1'b1, 8'h00, 32'd4);
        // both commands in one frame: fault wins
        for (int i = 0; i < 5; i++)
            send_byte_at(both_cmds[i], 32'd100 + i);
        send_item(1'b1, 8'h00, 32'd200);
        for (int i = 0; i < 3; i++)
            send_byte_at(both_cmds[i], 32'd300 + i);
        send_item(1'b1, 8'h00, 32'd400);
        // frame shorter than either command
        send_byte_at(8'hAA, 32'd500);
        send_item(1'b1, 8'h00, 32'd600);
        settle();

        write_settings(32'd0, {$urandom, $urandom}, 4'd4, {$urandom, $urandom}, 4'd2);
        run_phase(1'b0);
        write_settings(32'hFFFF_FFFF, '1, 4'd8, 64'd0, 4'd1);
        run_phase(1'b0);
        write_settings($urandom_range(1, 1000), {$urandom, $urandom}, 4'd15,
                       {$urandom, $urandom}, 4'd8);
        run_phase(1'b0);
        write_settings($urandom, {$urandom, $urandom}, 4'd0, {$urandom, $urandom},
                       ifcm_pkg::PAT_LEN_W'($urandom_range(1, 7)));
        run_phase(1'b0);
        write_settings(32'd1, {$urandom, $urandom}, 4'd1, {$urandom, $urandom}, 4'd0);
        run_phase(1'b0);
        write_settings(32'd7, {$urandom, $urandom},
                       ifcm_pkg::PAT_LEN_W'($urandom_range(2, 6)),
                       {$urandom, $urandom}, ifcm_pkg::PAT_LEN_W'($urandom_range(9, 15)));
        run_phase(1'b1);

        flush_check <= 1'b1;
        repeat (2) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
